>>> src/adp_pkg.sv
// Package for the data-processing ALU: command codes, channel structs and queue entry types.
package adp_pkg;

  localparam int DATA_W = 32;
  localparam int REG_W = 4;
  localparam int CMD_W = 5;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [REG_W-1:0] PC_INDEX = 4'd15;

  localparam logic [CMD_W-1:0] CMD_AND = 5'd0;
  localparam logic [CMD_W-1:0] CMD_EOR = 5'd1;
  localparam logic [CMD_W-1:0] CMD_SUB = 5'd2;
  localparam logic [CMD_W-1:0] CMD_RSB = 5'd3;
  localparam logic [CMD_W-1:0] CMD_ADD = 5'd4;
  localparam logic [CMD_W-1:0] CMD_ADC = 5'd5;
  localparam logic [CMD_W-1:0] CMD_SBC = 5'd6;
  localparam logic [CMD_W-1:0] CMD_RSC = 5'd7;
  localparam logic [CMD_W-1:0] CMD_TST = 5'd8;
  localparam logic [CMD_W-1:0] CMD_TEQ = 5'd9;
  localparam logic [CMD_W-1:0] CMD_CMP = 5'd10;
  localparam logic [CMD_W-1:0] CMD_CMN = 5'd11;
  localparam logic [CMD_W-1:0] CMD_ORR = 5'd12;
  localparam logic [CMD_W-1:0] CMD_MOV = 5'd13;
  localparam logic [CMD_W-1:0] CMD_BIC = 5'd14;
  localparam logic [CMD_W-1:0] CMD_MVN = 5'd15;
  localparam logic [CMD_W-1:0] CMD_MUL = 5'd16;
  localparam logic [CMD_W-1:0] CMD_MLA = 5'd17;

  // Flag register bit positions.
  localparam int FLAG_N_BIT = 3;
  localparam int FLAG_Z_BIT = 2;
  localparam int FLAG_C_BIT = 1;
  localparam int FLAG_V_BIT = 0;

  typedef enum logic [1:0] {
    CARRY_ZERO,
    CARRY_ONE,
    CARRY_FLAG
  } carry_mode_t;

  typedef enum logic [2:0] {
    FLAGS_KEEP,
    FLAGS_NZ,
    FLAGS_TOP,
    FLAGS_ARITH,
    FLAGS_LOGIC
  } flag_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic              shifter_carry;
    logic [DATA_W-1:0] accumulate_value;
    logic              set_flags;
    logic [REG_W-1:0]  dest_index;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              reg_write;
    logic [REG_W-1:0]  write_index;
    logic              branch_taken;
    logic              status_load;
    logic              flag_n;
    logic              flag_z;
    logic              flag_c;
    logic              flag_v;
  } out_item_t;

  // A classified operation waiting for the back end.
  typedef struct packed {
    logic              use_adder;
    logic [DATA_W-1:0] add_a;
    logic [DATA_W-1:0] add_b;
    carry_mode_t       carry_mode;
    logic [DATA_W-1:0] logic_result;
    logic              shifter_carry;
    flag_mode_t        flag_mode;
    logic              reg_write;
    logic [REG_W-1:0]  write_index;
    logic              branch_taken;
    logic              status_load;
  } queue_entry_t;

endpackage

>>> src/adp_front.sv
// Front end: decodes an incoming operation into adder operands, logic result and strobes.
module adp_front (
  input  adp_pkg::in_item_t     op,
  output adp_pkg::queue_entry_t entry
);

  logic [adp_pkg::DATA_W-1:0] a;
  logic [adp_pkg::DATA_W-1:0] b;
  logic [adp_pkg::DATA_W-1:0] product;
  logic                       known;
  logic                       is_mul;
  logic                       is_cmp;
  logic                       is_arith;
  logic                       to_pc;

  assign a = op.operand_a;
  assign b = op.operand_b;
  assign product = a * b;
  assign to_pc = (op.dest_index == adp_pkg::PC_INDEX);

  always_comb begin
    entry.use_adder     = 1'b0;
    entry.add_a         = '0;
    entry.add_b         = '0;
    entry.carry_mode    = adp_pkg::CARRY_ZERO;
    entry.logic_result  = '0;
    entry.shifter_carry = op.shifter_carry;
    known    = 1'b1;
    is_mul   = 1'b0;
    is_cmp   = 1'b0;
    is_arith = 1'b0;

    case (op.command)
      adp_pkg::CMD_AND: entry.logic_result = a & b;
      adp_pkg::CMD_EOR: entry.logic_result = a ^ b;
      adp_pkg::CMD_SUB: begin
        entry.add_a = a; entry.add_b = ~b; entry.carry_mode = adp_pkg::CARRY_ONE;
        is_arith = 1'b1;
      end
      adp_pkg::CMD_RSB: begin
        entry.add_a = b; entry.add_b = ~a; entry.carry_mode = adp_pkg::CARRY_ONE;
        is_arith = 1'b1;
      end
      adp_pkg::CMD_ADD: begin
        entry.add_a = a; entry.add_b = b;
        is_arith = 1'b1;
      end
      adp_pkg::CMD_ADC: begin
        entry.add_a = a; entry.add_b = b; entry.carry_mode = adp_pkg::CARRY_FLAG;
        is_arith = 1'b1;
      end
      adp_pkg::CMD_SBC: begin
        entry.add_a = a; entry.add_b = ~b; entry.carry_mode = adp_pkg::CARRY_FLAG;
        is_arith = 1'b1;
      end
      adp_pkg::CMD_RSC: begin
        entry.add_a = b; entry.add_b = ~a; entry.carry_mode = adp_pkg::CARRY_FLAG;
        is_arith = 1'b1;
      end
      adp_pkg::CMD_TST: begin
        entry.logic_result = a & b;
        is_cmp = 1'b1;
      end
      adp_pkg::CMD_TEQ: begin
        entry.logic_result = a ^ b;
        is_cmp = 1'b1;
      end
      adp_pkg::CMD_CMP: begin
        entry.add_a = a; entry.add_b = ~b; entry.carry_mode = adp_pkg::CARRY_ONE;
        is_arith = 1'b1;
        is_cmp   = 1'b1;
      end
      adp_pkg::CMD_CMN: begin
        entry.add_a = a; entry.add_b = b;
        is_arith = 1'b1;
        is_cmp   = 1'b1;
      end
      adp_pkg::CMD_ORR: entry.logic_result = a | b;
      adp_pkg::CMD_MOV: entry.logic_result = b;
      adp_pkg::CMD_BIC: entry.logic_result = a & ~b;
      adp_pkg::CMD_MVN: entry.logic_result = ~b;
      adp_pkg::CMD_MUL: begin
        entry.add_a = product;
        is_mul = 1'b1;
      end
      adp_pkg::CMD_MLA: begin
        entry.add_a = product; entry.add_b = op.accumulate_value;
        is_mul = 1'b1;
      end
      default: known = 1'b0;
    endcase

    // Multiplies reuse the back-end adder to fold in the accumulator.
    entry.use_adder = is_arith | is_mul;

    entry.reg_write    = 1'b0;
    entry.branch_taken = 1'b0;
    entry.status_load  = 1'b0;
    entry.flag_mode    = adp_pkg::FLAGS_KEEP;

    if (known) begin
      if (is_mul) begin
        entry.reg_write = !to_pc;
        if (!to_pc && op.set_flags) begin
          entry.flag_mode = adp_pkg::FLAGS_NZ;
        end
      end else if (to_pc) begin
        entry.branch_taken = !is_cmp;
        entry.status_load  = op.set_flags;
        if (op.set_flags) begin
          entry.flag_mode = adp_pkg::FLAGS_TOP;
        end
      end else begin
        entry.reg_write = !is_cmp;
        if (op.set_flags) begin
          entry.flag_mode = is_arith ? adp_pkg::FLAGS_ARITH : adp_pkg::FLAGS_LOGIC;
        end
      end
    end

    entry.write_index = entry.reg_write ? op.dest_index : '0;
  end

endmodule

>>> src/adp_queue.sv
// Short queue of decoded operations between the front end and the back end.
module adp_queue #(
  parameter int DEPTH = adp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  adp_pkg::queue_entry_t push_entry,
  output logic                  not_full,
  input  logic                  pop,
  output logic                  head_valid,
  output adp_pkg::queue_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  adp_pkg::queue_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign not_full   = (count != FULL_COUNT);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> src/adp_back.sv
// Back end: the adder, the NZCV flag register and the result register.
module adp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  adp_pkg::queue_entry_t head,
  output logic                  pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output adp_pkg::out_item_t    res
);

  logic [3:0]                 flags;
  logic [3:0]                 flags_next;
  logic                       carry_in;
  logic [adp_pkg::DATA_W:0]   sum;
  logic [adp_pkg::DATA_W-1:0] result;
  logic [1:0]                 nz;
  logic                       overflow;

  assign pop = head_valid && (!res_valid || res_ready);

  always_comb begin
    case (head.carry_mode)
      adp_pkg::CARRY_ONE:  carry_in = 1'b1;
      adp_pkg::CARRY_FLAG: carry_in = flags[adp_pkg::FLAG_C_BIT];
      default:             carry_in = 1'b0;
    endcase
  end

  assign sum = {1'b0, head.add_a} + {1'b0, head.add_b}
             + {{adp_pkg::DATA_W{1'b0}}, carry_in};
  assign result = head.use_adder ? sum[adp_pkg::DATA_W-1:0] : head.logic_result;
  assign nz = {result[adp_pkg::DATA_W-1], result == '0};
  // Signed overflow: operands agree in sign and the sum does not.
  assign overflow = ~(head.add_a[adp_pkg::DATA_W-1] ^ head.add_b[adp_pkg::DATA_W-1])
                  & (head.add_a[adp_pkg::DATA_W-1] ^ result[adp_pkg::DATA_W-1]);

  always_comb begin
    case (head.flag_mode)
      adp_pkg::FLAGS_NZ:    flags_next = {nz, flags[1:0]};
      adp_pkg::FLAGS_TOP:   flags_next = result[adp_pkg::DATA_W-1 -: 4];
      adp_pkg::FLAGS_ARITH: flags_next = {nz, sum[adp_pkg::DATA_W], overflow};
      adp_pkg::FLAGS_LOGIC: flags_next = {nz, head.shifter_carry, flags[adp_pkg::FLAG_V_BIT]};
      default:              flags_next = flags;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        flags <= flags_next;
      end
      if (pop) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.result_value <= result;
      res.reg_write    <= head.reg_write;
      res.write_index  <= head.write_index;
      res.branch_taken <= head.branch_taken;
      res.status_load  <= head.status_load;
      res.flag_n       <= flags_next[adp_pkg::FLAG_N_BIT];
      res.flag_z       <= flags_next[adp_pkg::FLAG_Z_BIT];
      res.flag_c       <= flags_next[adp_pkg::FLAG_C_BIT];
      res.flag_v       <= flags_next[adp_pkg::FLAG_V_BIT];
    end
  end

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !pop |=> $stable(flags))
    else $error("flags changed without an operation being executed");

  a_status_from_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status_load |->
      {res.flag_n, res.flag_z, res.flag_c, res.flag_v} == res.result_value[31:28])
    else $error("status load did not take flags from the result");

  a_write_not_branch: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.reg_write |-> !res.branch_taken && res.write_index != adp_pkg::PC_INDEX)
    else $error("register write and branch asserted together");

  a_flags_reported: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> {res.flag_n, res.flag_z, res.flag_c, res.flag_v} == flags)
    else $error("reported flags differ from the flag register");

endmodule

>>> src/arm_data_processing_alu.sv
// Top level of the data-processing ALU: front end, operation queue and back end.
//
// Executes one data-processing or multiply operation per transaction and keeps the NZCV
// condition flags. Operations enter on the op channel and leave on the res channel, both
// valid/ready; while res_ready stays high, one transaction can be accepted and one
// delivered in every clock cycle. An accepted transaction passes through the operation
// queue, whose depth is set by QUEUE_DEPTH, and then the result register. The sustained
// rate is bounded by the back end, where the 33-bit adder and the flag register close a
// loop through the carry flag used by ADC, SBC and RSC. The multiplier sits in the front
// end, so MLA adds its accumulator in the same back-end adder. The flags reported with
// each result are those after that operation; they reset to zero.
module arm_data_processing_alu #(
  parameter int QUEUE_DEPTH = adp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  output logic               op_ready,
  input  adp_pkg::in_item_t  op,
  output logic               res_valid,
  input  logic               res_ready,
  output adp_pkg::out_item_t res
);

  adp_pkg::queue_entry_t decoded;
  adp_pkg::queue_entry_t head;
  logic                  head_valid;
  logic                  pop;

  // Decoding is purely combinational, so the transaction is classified on its way in.
  adp_front u_front (
    .op    (op),
    .entry (decoded)
  );

  // The queue lets the producer keep issuing while a result waits to be taken.
  adp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (op_valid),
    .push_entry (decoded),
    .not_full   (op_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  adp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
